>>> rtl/wpx_pkg.sv
// ============================================================================
// wpx_pkg: shared types and constants for the wave channel extractor
// Beat structures for both channels, parser phases, result kinds, error
// codes and the four-character chunk tags in little-endian byte order.
// ============================================================================
package wpx_pkg;

    // One byte of the wave file on the input channel.
    typedef struct packed {
        logic [7:0] file_byte;
        logic       first_byte;
    } in_beat_t;

    // One result on the output channel.
    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [15:0] sample_value;
        logic [31:0]        rate_value;
        logic [2:0]         error_code;
        logic               finished;
    } out_beat_t;

    // Result of one parser step, handed to the output register.
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } step_result_t;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_CTAG  = 4'd3,
        PH_CSIZE = 4'd4,
        PH_FMT   = 4'd5,
        PH_DATA  = 4'd6,
        PH_SKIP  = 4'd7,
        PH_PAD   = 4'd8,
        PH_DONE  = 4'd9
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_RATE   = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    // Error codes.
    typedef enum logic [2:0] {
        ERR_RIFF_TAG  = 3'd0,
        ERR_WAVE_TAG  = 3'd1,
        ERR_TOO_LONG  = 3'd2,
        ERR_FMT_SIZE  = 3'd3,
        ERR_NOT_PCM   = 3'd4,
        ERR_CHANNEL   = 3'd5,
        ERR_NOT_16BIT = 3'd6,
        ERR_NO_FMT    = 3'd7
    } err_t;

    // Tags as they assemble from little-endian bytes.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Required size of the fmt chunk body.
    localparam logic [31:0] FMT_SIZE = 32'd16;

endpackage

>>> rtl/wpx_parser.sv
// ============================================================================
// wpx_parser: byte-wise RIFF/WAVE parse step and parser state
// Holds the parser state and applies one file byte per enabled cycle. The
// result of that byte, if any, is produced combinationally for the output
// register in the top level.
// ============================================================================
module wpx_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  wpx_pkg::in_beat_t    beat,
    input  logic [15:0]          chosen_channel,
    output wpx_pkg::step_result_t result
);
    import wpx_pkg::*;

    // Parser state registers.
    phase_t      phase_reg,     phase_next;
    logic [1:0]  fbi_reg,       fbi_next;
    logic [31:0] acc_reg,       acc_next;
    logic [31:0] riff_rem_reg,  riff_rem_next;
    logic [31:0] chunk_rem_reg, chunk_rem_next;
    logic [31:0] tag_reg,       tag_next;
    logic [15:0] chan_cnt_reg,  chan_cnt_next;
    logic [15:0] chan_pos_reg,  chan_pos_next;
    logic [7:0]  low_byte_reg,  low_byte_next;
    logic        fmt_seen_reg,  fmt_seen_next;
    logic        stopped_reg,   stopped_next;

    // Places byte b into a little-endian field; offset zero starts a new field.
    function automatic logic [31:0] gather(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [1:0] off);
        logic [31:0] placed;
        placed = {24'd0, b} << {off, 3'b000};
        return (off == 2'd0) ? placed : (acc | placed);
    endfunction

    // Byte offset within the fmt body field that holds body byte pos.
    function automatic logic [1:0] fmt_offset(input logic [3:0] pos);
        logic [1:0] off;
        case (pos)
            4'd4, 4'd5, 4'd6, 4'd7,
            4'd8, 4'd9, 4'd10, 4'd11: off = pos[1:0];
            default:                  off = {1'b0, pos[0]};
        endcase
        return off;
    endfunction

    // One parse step.
    always_comb begin
        logic [7:0]  b;
        logic [1:0]  idx;
        logic [3:0]  pos;
        logic [32:0] total;
        logic [16:0] cc2;
        logic [17:0] cc3;
        logic [16:0] pos_inc;
        logic        have;
        logic        body_end;
        logic        chunk_end;
        kind_t       kind;
        err_t        err;
        logic [15:0] sample;
        logic [31:0] rate;
        logic        fin;

        // A first byte restarts from the reset state.
        if (beat.first_byte) begin
            phase_next     = PH_RIFF;
            fbi_next       = 2'd0;
            acc_next       = 32'd0;
            riff_rem_next  = 32'd0;
            chunk_rem_next = 32'd0;
            tag_next       = 32'd0;
            chan_cnt_next  = 16'd0;
            chan_pos_next  = 16'd0;
            low_byte_next  = 8'd0;
            fmt_seen_next  = 1'b0;
            stopped_next   = 1'b0;
        end else begin
            phase_next     = phase_reg;
            fbi_next       = fbi_reg;
            acc_next       = acc_reg;
            riff_rem_next  = riff_rem_reg;
            chunk_rem_next = chunk_rem_reg;
            tag_next       = tag_reg;
            chan_cnt_next  = chan_cnt_reg;
            chan_pos_next  = chan_pos_reg;
            low_byte_next  = low_byte_reg;
            fmt_seen_next  = fmt_seen_reg;
            stopped_next   = stopped_reg;
        end

        b         = beat.file_byte;
        idx       = fbi_next;
        pos       = 4'd0 - chunk_rem_next[3:0];
        cc2       = {chan_cnt_next, 1'b0};
        cc3       = {1'b0, cc2} + {2'b00, chan_cnt_next};
        total     = 33'd0;
        pos_inc   = 17'd0;
        have      = 1'b0;
        body_end  = 1'b0;
        chunk_end = 1'b0;
        kind      = KIND_END;
        err       = ERR_RIFF_TAG;
        sample    = 16'd0;
        rate      = 32'd0;
        fin       = 1'b0;

        if (!(stopped_next || phase_next == PH_DONE)) begin
            case (phase_next)
                PH_RIFF: begin
                    if (b != TAG_RIFF[{idx, 3'b000} +: 8]) begin
                        stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                        err = ERR_RIFF_TAG;
                    end else begin
                        fbi_next = idx + 2'd1;
                        if (idx == 2'd3) phase_next = PH_RSIZE;
                    end
                end
                PH_RSIZE: begin
                    acc_next = gather(acc_next, b, idx);
                    fbi_next = idx + 2'd1;
                    if (idx == 2'd3) begin
                        riff_rem_next = acc_next;
                        phase_next    = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    if (b != TAG_WAVE[{idx, 3'b000} +: 8]) begin
                        stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                        err = ERR_WAVE_TAG;
                    end else begin
                        fbi_next = idx + 2'd1;
                        if (idx == 2'd3) begin
                            riff_rem_next = (riff_rem_next >= 32'd4) ?
                                            riff_rem_next - 32'd4 : 32'd0;
                            chunk_end = 1'b1;
                        end
                    end
                end
                PH_CTAG: begin
                    tag_next = gather(tag_next, b, idx);
                    fbi_next = idx + 2'd1;
                    if (idx == 2'd3) phase_next = PH_CSIZE;
                end
                PH_CSIZE: begin
                    acc_next = gather(acc_next, b, idx);
                    fbi_next = idx + 2'd1;
                    if (idx == 2'd3) begin
                        // Header end: charge header, body and pad to the RIFF size.
                        total = 33'd8 + {1'b0, acc_next} + {32'd0, acc_next[0]};
                        if ({1'b0, riff_rem_next} < total) begin
                            stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                            err = ERR_TOO_LONG;
                        end else begin
                            riff_rem_next  = riff_rem_next - total[31:0];
                            chunk_rem_next = acc_next;
                            if (tag_next == TAG_FMT) begin
                                if (acc_next != FMT_SIZE) begin
                                    stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                                    err = ERR_FMT_SIZE;
                                end else begin
                                    phase_next = PH_FMT;
                                end
                            end else if (tag_next == TAG_DATA) begin
                                if (!fmt_seen_next) begin
                                    stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                                    err = ERR_NO_FMT;
                                end else begin
                                    phase_next    = PH_DATA;
                                    chan_pos_next = 16'd0;
                                    fbi_next      = 2'd0;
                                    body_end      = (acc_next == 32'd0);
                                end
                            end else begin
                                phase_next = PH_SKIP;
                                body_end   = (acc_next == 32'd0);
                            end
                        end
                    end
                end
                PH_FMT: begin
                    acc_next       = gather(acc_next, b, fmt_offset(pos));
                    chunk_rem_next = chunk_rem_next - 32'd1;
                    if (pos == 4'd3) chan_cnt_next = acc_next[15:0];
                    if ((pos == 4'd0 && b != 8'd1) || (pos == 4'd1 && b != 8'd0)) begin
                        stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                        err = ERR_NOT_PCM;
                    end else if (pos == 4'd3 && chosen_channel >= acc_next[15:0]) begin
                        stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                        err = ERR_CHANNEL;
                    end else if (pos == 4'd7) begin
                        have = 1'b1; kind = KIND_RATE; rate = acc_next;
                    end else if (pos == 4'd13 &&
                                 (chan_cnt_next == 16'd0 ||
                                  {1'b0, acc_next[15:0]} < cc2 ||
                                  {2'b00, acc_next[15:0]} >= cc3)) begin
                        // Block align over channels, rounded down, must be exactly two bytes.
                        stopped_next = 1'b1; have = 1'b1; kind = KIND_ERROR;
                        err = ERR_NOT_16BIT;
                    end else if (pos == 4'd15) begin
                        fmt_seen_next = 1'b1;
                        acc_next      = 32'd0;
                        chunk_end     = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (fbi_next == 2'd0 && chan_pos_next == 16'd0 &&
                        chunk_rem_next < {15'd0, cc2}) begin
                        // Not enough bytes left for a whole frame; keep the size parity.
                        phase_next = PH_SKIP;
                        acc_next   = chunk_rem_next;
                    end else if (fbi_next == 2'd0) begin
                        low_byte_next = b;
                        fbi_next      = 2'd1;
                    end else begin
                        fbi_next = 2'd0;
                        if (chan_pos_next == chosen_channel) begin
                            have   = 1'b1;
                            kind   = KIND_SAMPLE;
                            sample = {b, low_byte_next};
                        end
                        pos_inc       = {1'b0, chan_pos_next} + 17'd1;
                        chan_pos_next = (pos_inc >= {1'b0, chan_cnt_next}) ?
                                        16'd0 : pos_inc[15:0];
                    end
                    chunk_rem_next = chunk_rem_next - 32'd1;
                    body_end       = (chunk_rem_next == 32'd0);
                end
                PH_SKIP: begin
                    if (chunk_rem_next != 32'd0) chunk_rem_next = chunk_rem_next - 32'd1;
                    body_end = (chunk_rem_next == 32'd0);
                end
                PH_PAD: begin
                    chunk_end = 1'b1;
                end
                default: begin
                end
            endcase

            // Body end: an odd size leaves one pad byte.
            if (body_end) begin
                if (acc_next[0]) phase_next = PH_PAD;
                else             chunk_end  = 1'b1;
            end

            // Chunk end: the content is over once the RIFF size is used up.
            if (chunk_end) begin
                if (riff_rem_next == 32'd0) begin
                    phase_next = PH_DONE;
                    fin        = 1'b1;
                end else begin
                    phase_next = PH_CTAG;
                    fbi_next   = 2'd0;
                end
            end
        end

        result.valid             = have || fin;
        result.beat.result_kind  = have ? kind : KIND_END;
        result.beat.sample_value = sample;
        result.beat.rate_value   = rate;
        result.beat.error_code   = (have && kind == KIND_ERROR) ? err : ERR_RIFF_TAG;
        result.beat.finished     = fin;
    end

    // State update on each byte taken from the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RIFF;
            fbi_reg       <= 2'd0;
            acc_reg       <= 32'd0;
            riff_rem_reg  <= 32'd0;
            chunk_rem_reg <= 32'd0;
            tag_reg       <= 32'd0;
            chan_cnt_reg  <= 16'd0;
            chan_pos_reg  <= 16'd0;
            low_byte_reg  <= 8'd0;
            fmt_seen_reg  <= 1'b0;
            stopped_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            fbi_reg       <= fbi_next;
            acc_reg       <= acc_next;
            riff_rem_reg  <= riff_rem_next;
            chunk_rem_reg <= chunk_rem_next;
            tag_reg       <= tag_next;
            chan_cnt_reg  <= chan_cnt_next;
            chan_pos_reg  <= chan_pos_next;
            low_byte_reg  <= low_byte_next;
            fmt_seen_reg  <= fmt_seen_next;
            stopped_reg   <= stopped_next;
        end
    end

endmodule

>>> rtl/wav_pcm16_channel_extractor_core.sv
// ============================================================================
// wav_pcm16_channel_extractor_core: RIFF/WAVE 16-bit PCM channel extractor
// Parses a wave file one byte per beat, reports the sample rate and emits
// the signed samples of one chosen channel, or an error or end marker.
// ============================================================================
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_valid/s_ready    s_beat  (file_byte, first_byte)
//  m_       out  m_valid/m_ready    m_beat  (result_kind .. finished)
//  cfg_     in   cfg_wr_en          cfg_wr_data (chosen channel)
//
// One byte is taken per cycle while the output is not stalled; a result
// passes from the input register through the parse logic into the output
// register. The parse state updates in the same cycle that it takes the result.
// Reset is synchronous to aclk and clears the parser and the chosen channel.
// A stalled output holds its beat; the input register keeps accepting as
// long as the parse step can move its byte on.
//
module wav_pcm16_channel_extractor_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wpx_pkg::in_beat_t  s_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output wpx_pkg::out_beat_t m_beat,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import wpx_pkg::*;

    logic         in_valid_reg,  in_valid_next;
    in_beat_t     in_beat_reg;
    logic         out_valid_reg, out_valid_next;
    out_beat_t    out_beat_reg;
    logic [15:0]  chosen_reg;
    logic         advance;
    step_result_t step_res;

    // The parse step runs whenever the output register can take its result.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance ? step_res.valid : (out_valid_reg && !m_ready);

    // Chosen channel register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chosen_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            chosen_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_beat;
        end
    end

    // Parser.
    wpx_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .beat           (in_beat_reg),
        .chosen_channel (chosen_reg),
        .result         (step_res)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.valid) begin
            out_beat_reg <= step_res.beat;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_beat  = out_beat_reg;

    // An accepted beat sits in the input register on the next cycle.
    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (in_valid_reg && in_beat_reg == $past(s_beat)))
        else $error("accepted input beat not captured");

    // Only a sample or the end marker can carry the finished flag.
    a_finished_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.finished) |->
            (m_beat.result_kind == KIND_SAMPLE || m_beat.result_kind == KIND_END))
        else $error("finished flag on a rate or error result");

    // An error result carries no sample and no rate.
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_beat.result_kind == KIND_ERROR) |->
            (m_beat.sample_value == 16'sd0 && m_beat.rate_value == 32'd0))
        else $error("error result with sample or rate payload");

    // A held result is never overwritten while the output is stalled.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("parse step advanced into a stalled output");

endmodule

>>> dv/tb_wav_pcm16_channel_extractor_core.sv
// ============================================================================
// tb_wav_pcm16_channel_extractor_core: self-checking bench for the extractor
// Builds wave files byte by byte, both well formed and broken, and feeds
// them through the input channel with random gaps. A software parser runs
// next to the block and queues the result, if any, due for each accepted byte. A
// separate process stalls the result channel at random and compares each
// result beat field by field with the oldest queued one.
// ============================================================================
module tb_wav_pcm16_channel_extractor_core;

    import wpx_pkg::*;

    localparam int          CYCLE_LIMIT  = 500000;
    localparam int          RANDOM_BYTES = 800;
    localparam int          TAIL_CYCLES  = 4;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] SAMPLE_BYTES = 16'd2;

    // Byte positions inside the fmt chunk body.
    localparam logic [3:0] FP_TAG_LO   = 4'd0;
    localparam logic [3:0] FP_TAG_HI   = 4'd1;
    localparam logic [3:0] FP_CH_HI    = 4'd3;
    localparam logic [3:0] FP_RATE_HI  = 4'd7;
    localparam logic [3:0] FP_ALIGN_HI = 4'd13;
    localparam logic [3:0] FP_LAST     = 4'd15;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_beat;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_beat;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    wav_pcm16_channel_extractor_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_beat      (s_beat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_beat      (m_beat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the parser state and of the chosen channel register.
    phase_t      parse_ph;
    logic [1:0]  fld_idx;
    logic [31:0] fld_acc;
    logic [31:0] riff_left;
    logic [31:0] chunk_left;
    logic [31:0] cur_tag;
    logic [15:0] n_channels;
    logic [15:0] chan_pos;
    logic [7:0]  low_byte;
    bit          have_fmt;
    bit          halted;
    logic [15:0] sel_channel;

    // Result of the byte being parsed.
    bit          res_valid;
    bit          res_fin;
    out_beat_t   res;

    out_beat_t   pending_results [$];
    logic [7:0]  wave_body [$];
    int          failures;
    int          bytes_sent;
    int          cycle_count;
    bit          tx_steady;
    bit          rx_steady;

    // Clock and watchdog.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Parser mirror
    // ------------------------------------------------------------------

    task automatic clear_parser();
        parse_ph   = PH_RIFF;
        fld_idx    = '0;
        fld_acc    = '0;
        riff_left  = '0;
        chunk_left = '0;
        cur_tag    = '0;
        n_channels = '0;
        chan_pos   = '0;
        low_byte   = '0;
        have_fmt   = 1'b0;
        halted     = 1'b0;
    endtask

    task automatic raise_error(err_t code);
        halted             = 1'b1;
        res_valid          = 1'b1;
        res.result_kind    = KIND_ERROR;
        res.error_code     = code;
    endtask

    // A chunk is over: either the RIFF content is used up or a new header follows.
    task automatic chunk_end();
        if (riff_left == 0) begin
            parse_ph = PH_DONE;
            res_fin  = 1'b1;
        end else begin
            parse_ph = PH_CTAG;
            fld_idx  = '0;
        end
    endtask

    // The body is over; an odd chunk size leaves one pad byte.
    task automatic body_end();
        if (fld_acc[0]) begin
            parse_ph = PH_PAD;
        end else begin
            chunk_end();
        end
    endtask

    // Steps the mirror by one accepted byte and queues the result it causes.
    task automatic parse_byte(logic [7:0] b, logic first);
        logic [1:0]  idx;
        logic [3:0]  pos;
        logic [3:0]  base;
        logic [32:0] need;
        if (first) begin
            clear_parser();
        end
        if (!halted && parse_ph != PH_DONE) begin
            res       = '0;
            res_valid = 1'b0;
            res_fin   = 1'b0;
            idx       = fld_idx;
            case (parse_ph)
                PH_RIFF: begin
                    if (b != TAG_RIFF[8*idx +: 8]) begin
                        raise_error(ERR_RIFF_TAG);
                    end else begin
                        fld_idx = idx + 2'd1;
                        if (idx == 2'd3) parse_ph = PH_RSIZE;
                    end
                end
                PH_RSIZE: begin
                    fld_acc = (idx == 0) ? 32'(b) : (fld_acc | (32'(b) << (8 * idx)));
                    fld_idx = idx + 2'd1;
                    if (idx == 2'd3) begin
                        riff_left = fld_acc;
                        parse_ph  = PH_WAVE;
                    end
                end
                PH_WAVE: begin
                    if (b != TAG_WAVE[8*idx +: 8]) begin
                        raise_error(ERR_WAVE_TAG);
                    end else begin
                        fld_idx = idx + 2'd1;
                        if (idx == 2'd3) begin
                            riff_left = (riff_left >= 4) ? riff_left - 32'd4 : 32'd0;
                            chunk_end();
                        end
                    end
                end
                PH_CTAG: begin
                    cur_tag = (idx == 0) ? 32'(b) : (cur_tag | (32'(b) << (8 * idx)));
                    fld_idx = idx + 2'd1;
                    if (idx == 2'd3) parse_ph = PH_CSIZE;
                end
                PH_CSIZE: begin
                    fld_acc = (idx == 0) ? 32'(b) : (fld_acc | (32'(b) << (8 * idx)));
                    fld_idx = idx + 2'd1;
                    if (idx == 2'd3) begin
                        // Header complete: the chunk plus its pad must fit the RIFF content.
                        need = 33'd8 + 33'(fld_acc) + 33'(fld_acc[0]);
                        if ({1'b0, riff_left} < need) begin
                            raise_error(ERR_TOO_LONG);
                        end else begin
                            riff_left  = riff_left - need[31:0];
                            chunk_left = fld_acc;
                            if (cur_tag == TAG_FMT) begin
                                if (fld_acc != FMT_SIZE) raise_error(ERR_FMT_SIZE);
                                else parse_ph = PH_FMT;
                            end else if (cur_tag == TAG_DATA && !have_fmt) begin
                                raise_error(ERR_NO_FMT);
                            end else begin
                                if (cur_tag == TAG_DATA) begin
                                    parse_ph = PH_DATA;
                                    chan_pos = '0;
                                    fld_idx  = '0;
                                end else begin
                                    parse_ph = PH_SKIP;
                                end
                                if (fld_acc == 0) body_end();
                            end
                        end
                    end
                end
                PH_FMT: begin
                    // Fields are 16 or 32 bits wide and assemble from their first byte on.
                    pos = 4'(32'd16 - chunk_left);
                    if (pos[3:2] == 2'b01 || pos[3:2] == 2'b10) base = {pos[3:2], 2'b00};
                    else base = {pos[3:1], 1'b0};
                    fld_acc = (pos == base) ? 32'(b)
                                            : (fld_acc | (32'(b) << (8 * (pos - base))));
                    chunk_left = chunk_left - 32'd1;
                    if ((pos == FP_TAG_LO && b != FMT_PCM[7:0]) ||
                        (pos == FP_TAG_HI && b != FMT_PCM[15:8])) begin
                        raise_error(ERR_NOT_PCM);
                    end else begin
                        if (pos == FP_CH_HI) n_channels = fld_acc[15:0];
                        if (pos == FP_CH_HI && sel_channel >= n_channels) begin
                            raise_error(ERR_CHANNEL);
                        end else if (pos == FP_ALIGN_HI && (n_channels == 0 ||
                                     fld_acc[15:0] / n_channels != SAMPLE_BYTES)) begin
                            raise_error(ERR_NOT_16BIT);
                        end else begin
                            if (pos == FP_RATE_HI) begin
                                res_valid       = 1'b1;
                                res.result_kind = KIND_RATE;
                                res.rate_value  = fld_acc;
                            end
                            if (pos == FP_LAST) begin
                                have_fmt = 1'b1;
                                fld_acc  = '0;
                                chunk_end();
                            end
                        end
                    end
                end
                PH_DATA: begin
                    // A frame that cannot complete sends the rest of the body to skipping.
                    if (fld_idx == 0 && chan_pos == 0 &&
                        chunk_left < 32'(n_channels) * 2) begin
                        parse_ph = PH_SKIP;
                        fld_acc  = chunk_left;
                    end else if (fld_idx == 0) begin
                        low_byte = b;
                        fld_idx  = 2'd1;
                    end else begin
                        fld_idx = '0;
                        if (chan_pos == sel_channel) begin
                            res_valid        = 1'b1;
                            res.result_kind  = KIND_SAMPLE;
                            res.sample_value = {b, low_byte};
                        end
                        chan_pos = chan_pos + 16'd1;
                        if (chan_pos >= n_channels) chan_pos = '0;
                    end
                    chunk_left = chunk_left - 32'd1;
                    if (chunk_left == 0) body_end();
                end
                PH_SKIP: begin
                    if (chunk_left != 0) chunk_left = chunk_left - 32'd1;
                    if (chunk_left == 0) body_end();
                end
                default: begin
                    chunk_end();
                end
            endcase
            if (res_valid || res_fin) begin
                if (!res_valid) res.result_kind = KIND_END;
                res.finished = res_fin;
                pending_results.push_back(res);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Sends one byte and updates the mirror at the edge that takes it.
    task automatic send_byte(logic [7:0] b, logic first);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_beat  <= {b, first};
        do @(posedge aclk); while (!s_ready);
        parse_byte(b, first);
        bytes_sent++;
    endtask

    // Waits until every queued result has arrived and the pipeline is empty.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic set_channel(logic [15:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sel_channel = value;
    endtask

    task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
            failures++;
        end
    endtask

    // Result side: random stalls, then each accepted beat is checked.
    initial begin
        int        stall;
        out_beat_t want;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                $error("result beat with none pending: kind %0d", m_beat.result_kind);
                failures++;
            end else begin
                want = pending_results.pop_front();
                compare_field("result_kind", 32'(want.result_kind), 32'(m_beat.result_kind));
                compare_field("sample_value", 32'(unsigned'(want.sample_value)),
                              32'(unsigned'(m_beat.sample_value)));
                compare_field("rate_value", want.rate_value, m_beat.rate_value);
                compare_field("error_code", 32'(want.error_code), 32'(m_beat.error_code));
                compare_field("finished", 32'(want.finished), 32'(m_beat.finished));
            end
        end
    end

    // ------------------------------------------------------------------
    // File building
    // ------------------------------------------------------------------

    task automatic put_le(logic [31:0] value, int nbytes);
        for (int i = 0; i < nbytes; i++) wave_body.push_back(value[8*i +: 8]);
    endtask

    task automatic add_header(logic [31:0] tag, logic [31:0] size);
        put_le(tag, 4);
        put_le(size, 4);
    endtask

    // Always writes a 16-byte body; the size field may say otherwise.
    task automatic add_fmt(logic [31:0] size, logic [15:0] fmt_tag, logic [15:0] ch,
                           logic [31:0] rate, logic [15:0] align, logic [15:0] bps);
        add_header(TAG_FMT, size);
        put_le(fmt_tag, 2);
        put_le(ch, 2);
        put_le(rate, 4);
        put_le(rate * align, 4);
        put_le(align, 2);
        put_le(bps, 2);
    endtask

    task automatic add_valid_fmt(logic [15:0] ch, logic [31:0] rate);
        add_fmt(FMT_SIZE, FMT_PCM, ch, rate, 16'(ch * SAMPLE_BYTES), 16'd16);
    endtask

    // Chunk with a body of sample-like bytes, biased toward the extremes.
    task automatic add_chunk(logic [31:0] tag, int size);
        add_header(tag, size);
        for (int i = 0; i < size; i++) begin
            case ($urandom_range(0, 5))
                0: wave_body.push_back(8'h00);
                1: wave_body.push_back(8'hFF);
                2: wave_body.push_back(8'h7F);
                3: wave_body.push_back(8'h80);
                default: wave_body.push_back(8'($urandom));
            endcase
        end
        if (size % 2 == 1) wave_body.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] junk_tag();
        logic [31:0] tag;
        do tag = $urandom; while (tag == TAG_FMT || tag == TAG_DATA);
        return tag;
    endfunction

    function automatic logic [31:0] riff_fit();
        return 32'(4 + wave_body.size());
    endfunction

    // Sends RIFF header, WAVE tag and the body built so far. One byte may be
    // corrupted and the file may be cut short; a negative value means neither.
    task automatic send_wave(logic [31:0] riff_size, int corrupt_at, int cut);
        logic [7:0] file [$];
        int         n;
        put_le(TAG_WAVE, 0);
        for (int i = 0; i < 4; i++) file.push_back(TAG_RIFF[8*i +: 8]);
        for (int i = 0; i < 4; i++) file.push_back(riff_size[8*i +: 8]);
        for (int i = 0; i < 4; i++) file.push_back(TAG_WAVE[8*i +: 8]);
        foreach (wave_body[i]) file.push_back(wave_body[i]);
        wave_body.delete();
        if (corrupt_at >= 0 && corrupt_at < file.size()) begin
            file[corrupt_at] = file[corrupt_at] ^ 8'($urandom_range(1, 255));
        end
        n = (cut >= 0 && cut < file.size()) ? cut : file.size();
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++) send_byte(file[i], i == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A wrong byte in either the RIFF or the WAVE tag.
    task automatic test_tag_errors();
        for (int k = 0; k < 12; k++) begin
            if (k < 4 || k >= 8) begin
                add_valid_fmt(16'd1, 32'd8000);
                add_chunk(TAG_DATA, 4);
                send_wave(riff_fit(), k, -1);
            end
        end
    endtask

    // RIFF sizes up to four end the file at the WAVE tag; the largest size
    // never ends it.
    task automatic test_short_riff();
        for (int sz = 0; sz <= 4; sz++) begin
            if (sz != 1 && sz != 2) begin
                add_valid_fmt(16'd1, 32'd8000);
                send_wave(32'(sz), -1, -1);
            end
        end
        add_valid_fmt(16'd2, 32'd44100);
        add_chunk(TAG_DATA, 8);
        send_wave(32'hFFFF_FFFF, -1, -1);
    endtask

    // Every check of the fmt chunk, and accepted corner settings.
    task automatic test_fmt_checks();
        set_channel(16'd0);
        for (int k = 0; k < 12; k++) begin
            case (k)
                0:  add_fmt(32'd18, FMT_PCM, 16'd1, 32'd8000, 16'd2, 16'd16);
                1:  add_fmt(32'd15, FMT_PCM, 16'd1, 32'd8000, 16'd2, 16'd16);
                2:  add_fmt(32'd0, FMT_PCM, 16'd1, 32'd8000, 16'd2, 16'd16);
                3:  add_fmt(FMT_SIZE, 16'h0003, 16'd1, 32'd8000, 16'd2, 16'd16);
                4:  add_fmt(FMT_SIZE, 16'h0101, 16'd1, 32'd8000, 16'd2, 16'd16);
                5:  add_fmt(FMT_SIZE, FMT_PCM, 16'd0, 32'd8000, 16'd0, 16'd16);
                6:  add_fmt(FMT_SIZE, FMT_PCM, 16'd1, 32'd8000, 16'd3, 16'd16);
                7:  add_fmt(FMT_SIZE, FMT_PCM, 16'd1, 32'd8000, 16'd1, 16'd16);
                8:  add_fmt(FMT_SIZE, FMT_PCM, 16'd2, 32'd22050, 16'd5, 16'd8);
                9:  add_fmt(FMT_SIZE, FMT_PCM, 16'hFFFF, 32'd8000, 16'hFFFF, 16'd16);
                10: add_fmt(FMT_SIZE, FMT_PCM, 16'd32767, 32'd0, 16'hFFFE, 16'd16);
                default: add_fmt(FMT_SIZE, FMT_PCM, 16'd1, 32'hFFFF_FFFF, 16'd2, 16'hFFFF);
            endcase
            add_chunk(TAG_DATA, 10);
            send_wave(riff_fit(), -1, -1);
        end
    endtask

    // Chunk walking: order, padding, empty chunks and the RIFF size bound.
    task automatic test_chunk_walk();
        logic [31:0] riff_size;
        // Data before any fmt chunk.
        add_chunk(TAG_DATA, 4);
        add_valid_fmt(16'd1, 32'd8000);
        send_wave(riff_fit(), -1, -1);
        // Unknown and empty chunks, odd data with trailing bytes, end on a pad byte.
        add_chunk(junk_tag(), 5);
        add_chunk(junk_tag(), 0);
        add_valid_fmt(16'd2, 32'd48000);
        add_chunk(TAG_DATA, 0);
        add_chunk(TAG_DATA, 11);
        add_chunk(junk_tag(), 1);
        send_wave(riff_fit(), -1, -1);
        // The end falls on a sample byte.
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 6);
        send_wave(riff_fit(), -1, -1);
        // Chunk one byte too long, and a pad byte that overruns.
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 6);
        send_wave(riff_fit() - 32'd1, -1, -1);
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 5);
        send_wave(riff_fit() - 32'd1, -1, -1);
        // Bytes after the end of the RIFF content are ignored.
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 6);
        riff_size = riff_fit();
        put_le($urandom, 4);
        put_le($urandom, 1);
        send_wave(riff_size, -1, -1);
        // A second fmt chunk, and a RIFF size that is never used up.
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 4);
        add_valid_fmt(16'd1, 32'd16000);
        add_chunk(TAG_DATA, 4);
        send_wave(riff_fit() + 32'd3, -1, -1);
    endtask

    task automatic test_sample_extremes();
        add_valid_fmt(16'd1, 32'd44100);
        add_header(TAG_DATA, 32'd10);
        put_le(32'h8000, 2);
        put_le(32'h7FFF, 2);
        put_le(32'h0000, 2);
        put_le(32'hFFFF, 2);
        put_le(32'h0001, 2);
        send_wave(riff_fit(), -1, -1);
    endtask

    // Channel selection across register settings, the extremes among them.
    task automatic test_channel_select();
        set_channel(16'hFFFF);
        add_valid_fmt(16'hFFFF, 32'd8000);
        send_wave(riff_fit(), -1, -1);
        add_valid_fmt(16'd4, 32'd8000);
        send_wave(riff_fit(), -1, -1);
        set_channel(16'd1);
        add_valid_fmt(16'd2, 32'd11025);
        add_chunk(TAG_DATA, 12);
        send_wave(riff_fit(), -1, -1);
        add_valid_fmt(16'd1, 32'd11025);
        send_wave(riff_fit(), -1, -1);
        set_channel(16'd2);
        add_valid_fmt(16'd3, 32'd96000);
        add_chunk(TAG_DATA, 14);
        send_wave(riff_fit(), -1, -1);
        set_channel(16'd0);
    endtask

    // Restarts in the middle of a file and after an error.
    task automatic test_restart();
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 20);
        send_wave(riff_fit(), -1, 30);
        add_valid_fmt(16'd1, 32'd8000);
        add_chunk(TAG_DATA, 8);
        send_wave(riff_fit(), 2, -1);
        for (int i = 0; i < 6; i++) send_byte(8'($urandom), 1'b0);
        add_valid_fmt(16'd2, 32'd32000);
        add_chunk(TAG_DATA, 8);
        send_wave(riff_fit(), -1, -1);
    endtask

    // Mostly well-formed files with random content, some broken, some noise.
    task automatic test_random();
        int          start;
        int          files;
        int          ch;
        int          frame;
        int          sz;
        logic [31:0] riff_size;
        start = bytes_sent;
        files = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (files % 8 == 0) begin
                set_channel(($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 3)));
            end
            files++;
            if ($urandom_range(0, 9) == 0) begin
                // Raw noise with stray restart flags.
                sz = $urandom_range(4, 30);
                tx_steady = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < sz; i++) begin
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
                end
            end else begin
                ch = int'(sel_channel) + $urandom_range(1, 3);
                if ($urandom_range(0, 9) == 0) ch = $urandom_range(0, sel_channel);
                if (ch > 65535) ch = 65535;
                frame = (ch <= 8) ? 2 * ch : 2;
                if ($urandom_range(0, 2) == 0) add_chunk(junk_tag(), $urandom_range(0, 9));
                case ($urandom_range(0, 15))
                    0: ;
                    1: add_fmt(32'($urandom_range(14, 18)), FMT_PCM, 16'(ch), $urandom,
                               16'(2 * ch), 16'd16);
                    2: add_fmt(FMT_SIZE, 16'($urandom_range(0, 3)), 16'(ch), $urandom,
                               16'(2 * ch), 16'd16);
                    3: add_fmt(FMT_SIZE, FMT_PCM, 16'(ch), $urandom,
                               16'($urandom_range(0, 4 * ch)), 16'd16);
                    default: add_fmt(FMT_SIZE, FMT_PCM, 16'(ch), $urandom, 16'(2 * ch),
                                     16'($urandom));
                endcase
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        add_chunk(junk_tag(), $urandom_range(0, 9));
                    end else if ($urandom_range(0, 3) == 0) begin
                        add_chunk(TAG_DATA, $urandom_range(0, 20));
                    end else begin
                        add_chunk(TAG_DATA, frame * $urandom_range(0, 4));
                    end
                end
                riff_size = riff_fit();
                if ($urandom_range(0, 7) == 0) riff_size = riff_size + $urandom_range(0, 6) - 3;
                send_wave(riff_size,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, wave_body.size() + 11)
                                                      : -1,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : -1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_beat      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        failures    = 0;
        bytes_sent  = 0;
        cycle_count = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        sel_channel = '0;
        clear_parser();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fmt_checks();
        test_tag_errors();
        test_short_riff();
        test_chunk_walk();
        test_sample_extremes();
        test_channel_select();
        test_restart();
        test_random();

        drain();
        repeat (2 * TAIL_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/wpx_pkg.sv
rtl/wpx_parser.sv
rtl/wav_pcm16_channel_extractor_core.sv
dv/tb_wav_pcm16_channel_extractor_core.sv
